/* design/kes_pkg.sv */
// Shared types, constants and key-code functions for the key event scanner.
package kes_pkg;

  localparam int RING_DEPTH = 32;
  localparam int PTR_W      = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam int WORD_W     = 16;
  localparam int KEY_W      = 8;
  localparam int KEYS       = 1 << KEY_W;

  typedef enum logic [1:0] {
    KIND_SCAN = 2'd0,
    KIND_KEY  = 2'd1,
    KIND_POP  = 2'd2
  } kind_t;

  // controller -> datapath
  typedef struct packed {
    logic clear_step;
    logic latch_item;
    logic do_scan;
    logic do_key;
    logic pop_empty;
    logic pop_read;
    logic pop_load;
  } kes_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic [1:0] kind;
    logic       ring_empty;
    logic       out_free;
    logic       clear_last;
  } kes_status_t;

  function automatic logic key_scanned(input logic [KEY_W-1:0] k);
    return k inside {[8'h08:8'h39], [8'h41:8'h5A], [8'h60:8'h75],
                     [8'hBA:8'hC0], [8'hDB:8'hDE]};
  endfunction

  function automatic logic [KEY_W-1:0] key_translate(input logic [KEY_W-1:0] k);
    logic [KEY_W-1:0] r;
    case (k)
      8'hBA:   r = 8'h3B;
      8'hBB:   r = 8'h3D;
      8'hBC:   r = 8'h2C;
      8'hBD:   r = 8'h2D;
      8'hBE:   r = 8'h2E;
      8'hBF:   r = 8'h2F;
      8'hC0:   r = 8'h60;
      8'hDB:   r = 8'h5B;
      8'hDC:   r = 8'h5C;
      8'hDD:   r = 8'h5D;
      default: r = k;
    endcase
    return r;
  endfunction

endpackage

/* design/key_event_scanner_fifo_core.sv */
// Top level of the key event scanner with its event ring.
// After reset the key level table is cleared one entry per cycle, and in_ready stays low
// until the last entry is cleared. Each input beat is then registered on accept with a
// read of the key's stored level, and applied to the key level, toggle and ring state in
// the execute state; a pop that finds events goes on to a load state for the registered
// ring read. The pop result beat sits in an output register; the next item is accepted
// while it waits; a second pop waits in its execute state until the register is free.
// Scan-start, key-sample and kind 3 items give no result beat. The ring holds RING_DEPTH
// (32) events with no full check: after RING_DEPTH unread pushes it reads as empty.
module key_event_scanner_fifo_core (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [1:0]                 kind,
  input  logic                       include_downs,
  input  logic [kes_pkg::KEY_W-1:0]  key_code,
  input  logic                       key_down,
  input  logic                       caps_down,
  input  logic                       num_down,
  input  logic                       scroll_down,
  input  logic                       insert_down,
  input  logic                       shift_down,
  input  logic                       ctrl_down,
  input  logic                       alt_down,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [kes_pkg::WORD_W-1:0] event_word,
  output logic                       was_empty
);

  kes_pkg::kes_cmd_t    cmd;
  kes_pkg::kes_status_t status;

  kes_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  kes_datapath u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .status        (status),
    .kind          (kind),
    .include_downs (include_downs),
    .key_code      (key_code),
    .key_down      (key_down),
    .caps_down     (caps_down),
    .num_down      (num_down),
    .scroll_down   (scroll_down),
    .insert_down   (insert_down),
    .shift_down    (shift_down),
    .ctrl_down     (ctrl_down),
    .alt_down      (alt_down),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .event_word    (event_word),
    .was_empty     (was_empty)
  );

endmodule

/* design/kes_ctrl.sv */
// Controller state machine: sequences accept, execute and ring read of one item.
module kes_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  kes_pkg::kes_status_t status,
  output kes_pkg::kes_cmd_t    cmd
);

  typedef enum logic [3:0] {
    S_CLEAR = 4'b0001,
    S_IDLE  = 4'b0010,
    S_EXEC  = 4'b0100,
    S_LOAD  = 4'b1000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      S_CLEAR: begin
        // zero the key level table one entry per cycle
        cmd.clear_step = 1'b1;
        if (status.clear_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.latch_item = 1'b1;
          state_next     = S_EXEC;
        end
      end
      S_EXEC: begin
        case (status.kind)
          kes_pkg::KIND_SCAN: begin
            cmd.do_scan = 1'b1;
            state_next  = S_IDLE;
          end
          kes_pkg::KIND_KEY: begin
            cmd.do_key = 1'b1;
            state_next = S_IDLE;
          end
          kes_pkg::KIND_POP: begin
            // hold until the output register can take the result beat
            if (status.out_free) begin
              if (status.ring_empty) begin
                cmd.pop_empty = 1'b1;
                state_next    = S_IDLE;
              end else begin
                cmd.pop_read = 1'b1;
                state_next   = S_LOAD;
              end
            end
          end
          default: state_next = S_IDLE;
        endcase
      end
      S_LOAD: begin
        cmd.pop_load = 1'b1;
        state_next   = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

/* design/kes_datapath.sv */
// Datapath: item latch, key level and toggle state, event ring and output register.
module kes_datapath (
  input  logic                              clk,
  input  logic                              rst,
  input  kes_pkg::kes_cmd_t                 cmd,
  output kes_pkg::kes_status_t              status,
  input  logic [1:0]                        kind,
  input  logic                              include_downs,
  input  logic [kes_pkg::KEY_W-1:0]         key_code,
  input  logic                              key_down,
  input  logic                              caps_down,
  input  logic                              num_down,
  input  logic                              scroll_down,
  input  logic                              insert_down,
  input  logic                              shift_down,
  input  logic                              ctrl_down,
  input  logic                              alt_down,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [kes_pkg::WORD_W-1:0]        event_word,
  output logic                              was_empty
);

  // latched item
  logic [1:0]                kind_r;
  logic                      downs_r;
  logic [kes_pkg::KEY_W-1:0] key_r;
  logic                      level_r;
  logic [3:0]                locks_r;
  logic [2:0]                mods_r;

  // block state
  logic                      prev_mem [kes_pkg::KEYS];
  logic                      prev_rd;
  logic [kes_pkg::KEY_W-1:0] clr_addr;
  logic [3:0]                prev_toggle_keys;
  logic [3:0]                toggle_bits;
  logic [2:0]                latched_modifiers;
  logic                      latched_include_downs;
  logic [kes_pkg::PTR_W-1:0] write_pointer;
  logic [kes_pkg::PTR_W-1:0] read_pointer;

  logic [kes_pkg::WORD_W-1:0] ring [kes_pkg::RING_DEPTH];
  logic [kes_pkg::WORD_W-1:0] rd_data;

  logic                       was_down;
  logic                       push;
  logic [kes_pkg::WORD_W-1:0] push_word;

  localparam logic [kes_pkg::PTR_W-1:0] PTR_LAST = kes_pkg::PTR_W'(kes_pkg::RING_DEPTH - 1);

  function automatic logic [kes_pkg::PTR_W-1:0] ptr_inc(input logic [kes_pkg::PTR_W-1:0] p);
    return (p == PTR_LAST) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk) begin
    if (cmd.latch_item) begin
      kind_r  <= kind;
      downs_r <= include_downs;
      key_r   <= key_code;
      level_r <= key_down;
      locks_r <= {insert_down, scroll_down, num_down, caps_down};
      mods_r  <= {alt_down, ctrl_down, shift_down};
    end
  end

  // key level table: read on accept, written in the execute cycle of a key beat
  always_ff @(posedge clk) begin
    if (cmd.clear_step) begin
      prev_mem[clr_addr] <= 1'b0;
    end else if (cmd.do_key) begin
      prev_mem[key_r] <= level_r;
    end
    if (cmd.latch_item) begin
      prev_rd <= prev_mem[key_code];
    end
  end

  assign was_down  = prev_rd;
  assign push      = cmd.do_key && kes_pkg::key_scanned(key_r) &&
                     ((latched_include_downs && level_r && !was_down) || (!level_r && was_down));
  assign push_word = {!level_r, latched_modifiers, toggle_bits, kes_pkg::key_translate(key_r)};

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr              <= '0;
      prev_toggle_keys      <= '0;
      toggle_bits           <= '0;
      latched_modifiers     <= '0;
      latched_include_downs <= 1'b0;
      write_pointer         <= '0;
      read_pointer          <= '0;
    end else begin
      if (cmd.clear_step) begin
        clr_addr <= clr_addr + 1'b1;
      end
      if (cmd.do_scan) begin
        toggle_bits           <= toggle_bits ^ (locks_r & ~prev_toggle_keys);
        prev_toggle_keys      <= locks_r;
        latched_modifiers     <= mods_r;
        latched_include_downs <= downs_r;
      end
      // no full check: overrunning the ring makes it read as empty
      if (push) begin
        write_pointer <= ptr_inc(write_pointer);
      end
      if (cmd.pop_read) begin
        read_pointer <= ptr_inc(read_pointer);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ring[write_pointer] <= push_word;
    end
    rd_data <= ring[read_pointer];
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.pop_empty || cmd.pop_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.pop_empty) begin
      event_word <= '0;
      was_empty  <= 1'b1;
    end else if (cmd.pop_load) begin
      event_word <= rd_data;
      was_empty  <= 1'b0;
    end
  end

  assign status.kind       = kind_r;
  assign status.ring_empty = (read_pointer == write_pointer);
  assign status.out_free   = !out_valid || out_ready;
  assign status.clear_last = (clr_addr == '1);

  a_read_not_empty: assert property (@(posedge clk) disable iff (rst)
    cmd.pop_read |-> (read_pointer != write_pointer))
    else $error("ring read issued while empty");

  a_load_shows_beat: assert property (@(posedge clk) disable iff (rst)
    (cmd.pop_load || cmd.pop_empty) |=> out_valid)
    else $error("pop result not presented");

  a_empty_word_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && was_empty) |-> (event_word == '0))
    else $error("empty pop carries a nonzero word");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |-> !(cmd.pop_empty || cmd.pop_read))
    else $error("pending result beat would be overwritten");

endmodule

/* tb/key_event_scanner_fifo_core_tb.sv */
// Self-checking testbench for the key event scanner core: predicts every pop beat and compares.
module key_event_scanner_fifo_core_tb;

  localparam logic [1:0] KIND_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 20;

  typedef struct {
    logic [1:0]                kind;
    logic                      include_downs;
    logic [kes_pkg::KEY_W-1:0] key_code;
    logic                      key_down;
    logic [3:0]                locks;  // caps, num, scroll, insert
    logic [2:0]                mods;   // shift, ctrl, alt
  } key_beat_t;

  typedef struct {
    logic [kes_pkg::WORD_W-1:0] word;
    logic                       empty;
  } pop_result_t;

  logic clk = 1'b0;
  logic rst;
  logic in_valid;
  logic in_ready;
  logic [1:0] kind;
  logic include_downs;
  logic [kes_pkg::KEY_W-1:0] key_code;
  logic key_down;
  logic caps_down, num_down, scroll_down, insert_down;
  logic shift_down, ctrl_down, alt_down;
  logic out_valid;
  logic out_ready;
  logic [kes_pkg::WORD_W-1:0] event_word;
  logic was_empty;

  // scanner state as the block should hold it
  logic                       key_level [kes_pkg::KEYS];
  logic [3:0]                 lock_level_prev;
  logic [3:0]                 lock_toggles;
  logic [2:0]                 mod_latch;
  logic                       downs_latch;
  logic [kes_pkg::WORD_W-1:0] ring_copy [kes_pkg::RING_DEPTH];
  int                         ring_wr;
  int                         ring_rd;

  pop_result_t pop_results_due[$];

  int err_count   = 0;
  int cycle_count = 0;

  // receiver stall control
  bit          hold_req = 1'b0;
  int          hold_left;
  int          ready_phase;
  int          ready_style;
  logic [31:0] ready_bits;

  key_event_scanner_fifo_core u_dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .kind         (kind),
    .include_downs(include_downs),
    .key_code     (key_code),
    .key_down     (key_down),
    .caps_down    (caps_down),
    .num_down     (num_down),
    .scroll_down  (scroll_down),
    .insert_down  (insert_down),
    .shift_down   (shift_down),
    .ctrl_down    (ctrl_down),
    .alt_down     (alt_down),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .event_word   (event_word),
    .was_empty    (was_empty)
  );

  always #10 clk = ~clk;

  task automatic report_mismatch(input string what);
    if (err_count < 100) $display("ERROR cycle %0d: %s", cycle_count, what);
    err_count++;
  endtask

  // Apply one accepted beat to the scanner state; pops queue their expected result.
  task automatic scanner_update(input key_beat_t b);
    logic [3:0]                 rising;
    logic [kes_pkg::WORD_W-1:0] word;
    logic [kes_pkg::KEY_W-1:0]  code;
    logic                       was_down;
    logic                       scanned;
    logic                       push;
    pop_result_t                r;
    case (b.kind)
      kes_pkg::KIND_SCAN: begin
        rising          = b.locks & ~lock_level_prev;
        lock_toggles    = lock_toggles ^ rising;
        lock_level_prev = b.locks;
        mod_latch       = b.mods;
        downs_latch     = b.include_downs;
      end
      kes_pkg::KIND_KEY: begin
        case (b.key_code)
          8'hBA:   code = 8'h3B;
          8'hBB:   code = 8'h3D;
          8'hBC:   code = 8'h2C;
          8'hBD:   code = 8'h2D;
          8'hBE:   code = 8'h2E;
          8'hBF:   code = 8'h2F;
          8'hC0:   code = 8'h60;
          8'hDB:   code = 8'h5B;
          8'hDC:   code = 8'h5C;
          8'hDD:   code = 8'h5D;
          default: code = b.key_code;
        endcase
        scanned = (b.key_code >= 8'h08 && b.key_code <= 8'h39) ||
                  (b.key_code >= 8'h41 && b.key_code <= 8'h5A) ||
                  (b.key_code >= 8'h60 && b.key_code <= 8'h75) ||
                  (b.key_code >= 8'hBA && b.key_code <= 8'hC0) ||
                  (b.key_code >= 8'hDB && b.key_code <= 8'hDE);
        was_down = key_level[b.key_code];
        key_level[b.key_code] = b.key_down;
        word = {1'b0, mod_latch, lock_toggles, code};
        push = 1'b0;
        if (scanned) begin
          if (downs_latch && b.key_down && !was_down) begin
            push = 1'b1;
          end else if (!b.key_down && was_down) begin
            push = 1'b1;
            word[15] = 1'b1;
          end
        end
        // no full check: an overrun makes the ring look empty
        if (push) begin
          ring_copy[ring_wr] = word;
          ring_wr = (ring_wr + 1) % kes_pkg::RING_DEPTH;
        end
      end
      kes_pkg::KIND_POP: begin
        if (ring_rd == ring_wr) begin
          r.word  = '0;
          r.empty = 1'b1;
        end else begin
          r.word  = ring_copy[ring_rd];
          r.empty = 1'b0;
          ring_rd = (ring_rd + 1) % kes_pkg::RING_DEPTH;
        end
        pop_results_due.push_back(r);
      end
      default: ;
    endcase
  endtask

  // Drive one beat, hold it until accepted, then predict. Valid is left high.
  task automatic send_beat(input key_beat_t b);
    in_valid      <= 1'b1;
    kind          <= b.kind;
    include_downs <= b.include_downs;
    key_code      <= b.key_code;
    key_down      <= b.key_down;
    caps_down     <= b.locks[0];
    num_down      <= b.locks[1];
    scroll_down   <= b.locks[2];
    insert_down   <= b.locks[3];
    shift_down    <= b.mods[0];
    ctrl_down     <= b.mods[1];
    alt_down      <= b.mods[2];
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    scanner_update(b);
  endtask

  // unused fields carry random values so that they are seen to be ignored
  function automatic key_beat_t filler_beat();
    key_beat_t b;
    b.kind          = 2'($urandom);
    b.include_downs = 1'($urandom);
    b.key_code      = 8'($urandom);
    b.key_down      = 1'($urandom);
    b.locks         = 4'($urandom);
    b.mods          = 3'($urandom);
    return b;
  endfunction

  function automatic key_beat_t scan_beat(input logic inc, input logic [3:0] locks,
                                          input logic [2:0] mods);
    key_beat_t b;
    b = filler_beat();
    b.kind          = kes_pkg::KIND_SCAN;
    b.include_downs = inc;
    b.locks         = locks;
    b.mods          = mods;
    return b;
  endfunction

  function automatic key_beat_t key_beat(input logic [kes_pkg::KEY_W-1:0] code,
                                         input logic down);
    key_beat_t b;
    b = filler_beat();
    b.kind     = kes_pkg::KIND_KEY;
    b.key_code = code;
    b.key_down = down;
    return b;
  endfunction

  function automatic key_beat_t pop_beat();
    key_beat_t b;
    b = filler_beat();
    b.kind = kes_pkg::KIND_POP;
    return b;
  endfunction

  function automatic logic [kes_pkg::KEY_W-1:0] pick_scanned_code();
    case ($urandom_range(0, 4))
      0:       return 8'($urandom_range(8'h08, 8'h39));
      1:       return 8'($urandom_range(8'h41, 8'h5A));
      2:       return 8'($urandom_range(8'h60, 8'h75));
      3:       return 8'($urandom_range(8'hBA, 8'hC0));
      default: return 8'($urandom_range(8'hDB, 8'hDE));
    endcase
  endfunction

  task automatic test_directed();
    key_beat_t b;
    send_beat(pop_beat());                          // empty ring
    send_beat(scan_beat(1'b1, 4'b1111, 3'b111));
    send_beat(key_beat(8'h41, 1'b1));
    send_beat(key_beat(8'hBA, 1'b1));
    send_beat(key_beat(8'h41, 1'b0));
    send_beat(key_beat(8'hFF, 1'b1));               // outside scanned ranges
    send_beat(key_beat(8'hFF, 1'b0));
    send_beat(key_beat(8'h00, 1'b1));
    b = filler_beat();
    b.kind = KIND_UNUSED;
    send_beat(b);
    send_beat(scan_beat(1'b0, 4'b0000, 3'b000));
    send_beat(key_beat(8'h08, 1'b1));               // press, downs not included
    send_beat(key_beat(8'h08, 1'b0));
    send_beat(key_beat(8'hBA, 1'b0));
    send_beat(key_beat(8'hDD, 1'b1));
    send_beat(key_beat(8'hDD, 1'b0));
    send_beat(scan_beat(1'b1, 4'b0101, 3'b010));
    send_beat(key_beat(8'hDE, 1'b1));
    repeat (8) send_beat(pop_beat());
  endtask

  // 32 unread pushes bring the pointers together again
  task automatic test_ring_overflow();
    int i;
    send_beat(scan_beat(1'b1, 4'($urandom), 3'($urandom)));
    for (i = 0; i < kes_pkg::RING_DEPTH; i++)
      send_beat(key_beat((i < 25) ? 8'(8'h42 + i) : 8'(8'h30 + i - 25), 1'b1));
    send_beat(pop_beat());
    for (i = 0; i < 3; i++) send_beat(key_beat(8'(8'h42 + i), 1'b0));
    repeat (4) send_beat(pop_beat());
  endtask

  // receiver holds off while pops keep coming, so the input must stall
  task automatic test_output_backpressure();
    int i;
    hold_req = 1'b1;
    send_beat(scan_beat(1'b1, 4'($urandom), 3'($urandom)));
    for (i = 0; i < 40; i++) begin
      if ($urandom_range(0, 2) == 0)
        send_beat(key_beat(pick_scanned_code(), 1'($urandom)));
      else
        send_beat(pop_beat());
    end
  endtask

  task automatic test_random_traffic(input int n_items);
    key_beat_t                 b;
    logic [kes_pkg::KEY_W-1:0] pool [6];
    int                        r;
    int                        gap;
    int                        burst_left;
    int                        seq_left;
    int                        i;
    burst_left = 0;
    seq_left   = 0;
    i          = 0;
    while (i < n_items) begin
      if (burst_left == 0) begin
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        if (gap > 0) begin
          in_valid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
        burst_left = ($urandom_range(0, 7) == 0) ? 200 : $urandom_range(1, 24);
      end
      burst_left--;
      if (seq_left == 0) begin
        // new scan window over a small key pool so presses and releases pair up
        foreach (pool[j]) pool[j] = ($urandom_range(0, 9) == 0) ? 8'($urandom)
                                                                : pick_scanned_code();
        seq_left = $urandom_range(4, 40);
        b = scan_beat($urandom_range(0, 3) != 0, 4'($urandom), 3'($urandom));
      end else begin
        seq_left--;
        r = $urandom_range(0, 99);
        if (r < 55) begin
          b = key_beat(pool[$urandom_range(0, 5)], 1'($urandom));
        end else if (r < 85) begin
          b = pop_beat();
        end else if (r < 90) begin
          b = filler_beat();
          b.kind = KIND_UNUSED;
        end else if (r < 95) begin
          b = key_beat(8'($urandom), 1'($urandom));
        end else begin
          b = scan_beat(1'($urandom), 4'($urandom), 3'($urandom));
        end
      end
      send_beat(b);
      i++;
    end
  endtask

  // result checker
  always @(posedge clk) begin : check_results
    pop_result_t due;
    if (!rst && out_valid && out_ready) begin
      if (pop_results_due.size() == 0) begin
        report_mismatch($sformatf("unexpected result beat word=%h empty=%b",
                                  event_word, was_empty));
      end else begin
        due = pop_results_due.pop_front();
        if (event_word !== due.word)
          report_mismatch($sformatf("event_word %h, want %h", event_word, due.word));
        if (was_empty !== due.empty)
          report_mismatch($sformatf("was_empty %b, want %b", was_empty, due.empty));
      end
    end
  end

  // receiver: changing stall styles, plus a long hold-off on request
  always @(posedge clk) begin
    if (rst) begin
      out_ready   <= 1'b0;
      hold_left   = 0;
      ready_phase = 0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else if (hold_req) begin
      hold_req  = 1'b0;
      hold_left = HOLD_CYCLES;
      out_ready <= 1'b0;
    end else begin
      if (ready_phase == 0) begin
        ready_phase = 64;
        ready_style = $urandom_range(0, 3);
        ready_bits  = $urandom;
      end
      ready_phase--;
      case (ready_style)
        0:       out_ready <= 1'b1;
        1:       out_ready <= ready_bits[ready_phase % 32];
        2:       out_ready <= ($urandom_range(0, 3) == 0);
        default: out_ready <= ($urandom_range(0, 3) != 0);
      endcase
    end
  end

  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    rst           = 1'b1;
    in_valid      = 1'b0;
    kind          = '0;
    include_downs = 1'b0;
    key_code      = '0;
    key_down      = 1'b0;
    caps_down     = 1'b0;
    num_down      = 1'b0;
    scroll_down   = 1'b0;
    insert_down   = 1'b0;
    shift_down    = 1'b0;
    ctrl_down     = 1'b0;
    alt_down      = 1'b0;
    foreach (key_level[k]) key_level[k] = 1'b0;
    foreach (ring_copy[k]) ring_copy[k] = '0;
    lock_level_prev = '0;
    lock_toggles    = '0;
    mod_latch       = '0;
    downs_latch     = 1'b0;
    ring_wr         = 0;
    ring_rd         = 0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    test_directed();
    test_ring_overflow();
    test_output_backpressure();
    test_random_traffic(1850);

    in_valid <= 1'b0;
    while (pop_results_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (err_count == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule
